[hw/rtl/brf_pkg.sv]
// Shared types, codes and helper functions for the banked register file.
`default_nettype none
package brf_pkg;

	localparam int GPR_PHYS = 31;
	localparam int GPR_AW = $clog2(GPR_PHYS);
	localparam int SPSR_NUM = 5;
	localparam int SPSR_AW = $clog2(SPSR_NUM);

	localparam logic [4:0] MODE_USR = 5'h10;
	localparam logic [4:0] MODE_FIQ = 5'h11;
	localparam logic [4:0] MODE_IRQ = 5'h12;
	localparam logic [4:0] MODE_SVC = 5'h13;
	localparam logic [4:0] MODE_ABT = 5'h17;
	localparam logic [4:0] MODE_UND = 5'h1B;
	localparam logic [4:0] MODE_SYS = 5'h1F;

	localparam logic [31:0] PSR_MODE_BIT4 = 32'h0000_0010;
	localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;

	localparam logic [GPR_AW-1:0] PHYS_FIQ_R8 = GPR_AW'(13);
	localparam logic [GPR_AW-1:0] PHYS_BANK_R13 = GPR_AW'(18);
	localparam logic [GPR_AW-1:0] PHYS_R15 = GPR_AW'(30);

	typedef enum logic [2:0] {
		REQ_RD_REG  = 3'd0,
		REQ_WR_REG  = 3'd1,
		REQ_RD_CPSR = 3'd2,
		REQ_WR_CPSR = 3'd3,
		REQ_RD_SPSR = 3'd4,
		REQ_WR_SPSR = 3'd5,
		REQ_COND    = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		BANK_USR = 3'd0,
		BANK_FIQ = 3'd1,
		BANK_IRQ = 3'd2,
		BANK_SVC = 3'd3,
		BANK_ABT = 3'd4,
		BANK_UND = 3'd5
	} bank_t;

	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_CS = 4'd2,
		COND_CC = 4'd3,
		COND_MI = 4'd4,
		COND_PL = 4'd5,
		COND_VS = 4'd6,
		COND_VC = 4'd7,
		COND_HI = 4'd8,
		COND_LS = 4'd9,
		COND_GE = 4'd10,
		COND_LT = 4'd11,
		COND_GT = 4'd12,
		COND_LE = 4'd13,
		COND_AL = 4'd14,
		COND_NV = 4'd15
	} cond_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [3:0]  cond_code;
	} in_word_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        cond_pass;
		logic        status;
	} out_word_t;

	function automatic logic mode_ok(input logic [4:0] mode);
		logic ok;
		case (mode)
			MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
			MODE_ABT, MODE_UND, MODE_SYS: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic bank_t mode_bank(input logic [4:0] mode);
		bank_t b;
		case (mode)
			MODE_FIQ: b = BANK_FIQ;
			MODE_IRQ: b = BANK_IRQ;
			MODE_SVC: b = BANK_SVC;
			MODE_ABT: b = BANK_ABT;
			MODE_UND: b = BANK_UND;
			default:  b = BANK_USR;
		endcase
		return b;
	endfunction

	function automatic logic [GPR_AW-1:0] phys_idx(input logic [3:0] idx, input bank_t b);
		logic [GPR_AW-1:0] p;
		if (idx == 4'd15) begin
			p = PHYS_R15;
		end else if (idx inside {4'd13, 4'd14}) begin
			p = PHYS_BANK_R13 + {1'b0, b, 1'b0} + {4'd0, ~idx[0]};
		end else if (idx inside {[4'd8:4'd12]} && b == BANK_FIQ) begin
			p = PHYS_FIQ_R8 + {1'b0, idx - 4'd8};
		end else begin
			p = {1'b0, idx};
		end
		return p;
	endfunction

	function automatic logic [SPSR_AW-1:0] spsr_idx(input bank_t b);
		return SPSR_AW'(b - BANK_FIQ);
	endfunction

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] nzcv);
		logic n, z, c, v, r;
		n = nzcv[3];
		z = nzcv[2];
		c = nzcv[1];
		v = nzcv[0];
		case (cond_t'(cond))
			COND_EQ: r = z;
			COND_NE: r = !z;
			COND_CS: r = c;
			COND_CC: r = !c;
			COND_MI: r = n;
			COND_PL: r = !n;
			COND_VS: r = v;
			COND_VC: r = !v;
			COND_HI: r = c && !z;
			COND_LS: r = !c || z;
			COND_GE: r = n == v;
			COND_LT: r = n != v;
			COND_GT: r = !z && (n == v);
			COND_LE: r = z || (n != v);
			COND_AL: r = 1'b1;
			COND_NV: r = 1'b0;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/brf_gpr.sv]
// Physical general-purpose registers, one read and one write port.
`default_nettype none
module brf_gpr
	import brf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [GPR_AW-1:0] rd_addr,
	output logic [31:0]            rd_data,
	input  wire logic              wr_en,
	input  wire logic [GPR_AW-1:0] wr_addr,
	input  wire logic [31:0]       wr_data
);

	logic [31:0] regs_q [GPR_PHYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GPR_PHYS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_en) begin
			regs_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = regs_q[rd_addr];

endmodule
`default_nettype wire

[hw/rtl/banked_register_file_with_psr_top.sv]
// Banked register file with CPSR/SPSR and condition evaluation.
// Each accepted word is held in an input register, then its result is held in a result register.
// Throughput: one word per cycle while out_ready does not stall the output; each word executes in a single pass
// against the register state left by the word before it.
// Reset: registers and SPSRs clear to zero, CPSR to 0xD3 (SVC, IRQ/FIQ masked).
`default_nettype none
module banked_register_file_with_psr_top
	import brf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	logic        valid_s1;
	in_word_t    word_s1;
	logic        out_valid_q;
	out_word_t   out_data_q;
	logic [31:0] cpsr_q;
	logic [31:0] spsr_q [SPSR_NUM];

	logic              adv;
	bank_t             cur_bank;
	logic [GPR_AW-1:0] gpr_addr;
	logic [31:0]       gpr_rdata;
	logic              gpr_wr;
	logic [31:0]       new_psr;
	logic              new_ok;
	logic              has_spsr;
	logic [31:0]       spsr_rd;
	out_word_t         result;

	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign cur_bank = mode_bank(cpsr_q[4:0]);
	assign gpr_addr = phys_idx(word_s1.reg_index, cur_bank);
	assign gpr_wr = adv && req_t'(word_s1.req_type) == REQ_WR_REG;
	assign new_psr = word_s1.write_data | PSR_MODE_BIT4;
	assign new_ok = mode_ok(new_psr[4:0]);
	assign has_spsr = cur_bank != BANK_USR;
	assign spsr_rd = has_spsr ? spsr_q[spsr_idx(cur_bank)] : cpsr_q;

	brf_gpr u_gpr (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (gpr_addr),
		.rd_data (gpr_rdata),
		.wr_en   (gpr_wr),
		.wr_addr (gpr_addr),
		.wr_data (word_s1.write_data)
	);

	always_comb begin
		result = '0;
		case (req_t'(word_s1.req_type))
			REQ_RD_REG:  result.read_data = gpr_rdata;
			REQ_RD_CPSR: result.read_data = cpsr_q;
			REQ_WR_CPSR: result.status = !new_ok;
			REQ_RD_SPSR: result.read_data = spsr_rd;
			REQ_COND:    result.cond_pass = cond_holds(word_s1.cond_code, cpsr_q[31:28]);
			default:     result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpsr_q <= CPSR_RESET;
		end else if (adv && req_t'(word_s1.req_type) == REQ_WR_CPSR && new_ok) begin
			cpsr_q <= new_psr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SPSR_NUM; i++) begin
				spsr_q[i] <= '0;
			end
		end else if (adv && req_t'(word_s1.req_type) == REQ_WR_SPSR && has_spsr) begin
			spsr_q[spsr_idx(cur_bank)] <= word_s1.write_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_cpsr_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mode_ok(cpsr_q[4:0]) && cpsr_q[4])
		else $error("CPSR holds an invalid mode");

	a_bad_mode_keeps_cpsr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_t'(word_s1.req_type) == REQ_WR_CPSR && !new_ok |=> $stable(cpsr_q))
		else $error("rejected CPSR write changed CPSR");

	a_idle_keeps_cpsr: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cpsr_q))
		else $error("CPSR changed without an executing word");

	a_result_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("executed word produced no result");

endmodule
`default_nettype wire

[bench/banked_register_file_with_psr_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the banked register file: directed request table, then random requests.
module banked_register_file_with_psr_top_tb;
	import brf_pkg::*;

	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_WORDS = 1400;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 64;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		in_word_t  word;
		bit        typed;
		out_word_t want;
	} script_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	logic [31:0] gpr_common [16] = '{default: '0};
	logic [31:0] gpr_fiq [8:12] = '{default: '0};
	logic [31:0] sp_bank [6] = '{default: '0};
	logic [31:0] lr_bank [6] = '{default: '0};
	logic [31:0] saved_psr [6] = '{default: '0};
	logic [31:0] cpsr = CPSR_RESET;

	out_word_t pending_results [$];
	int mismatches = 0;
	int results_seen = 0;

	logic [4:0] legal_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
		MODE_ABT, MODE_UND, MODE_SYS};

	script_row_t script [26] = '{
		'{'{REQ_RD_CPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b1, '{CPSR_RESET, 1'b0, 1'b0}},
		'{'{REQ_RD_REG, 4'd0, 32'hFFFF_FFFF, COND_NV}, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{'{REQ_RD_REG, 4'd15, 32'h0000_0000, COND_EQ}, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{'{REQ_RD_SPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{'{REQ_COND, 4'd0, 32'h0000_0000, COND_AL}, 1'b1, '{32'h0, 1'b1, 1'b0}},
		'{'{REQ_COND, 4'd15, 32'hFFFF_FFFF, COND_NV}, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{'{REQ_WR_CPSR, 4'd0, 32'hFFFF_FFE4, COND_EQ}, 1'b1, '{32'h0, 1'b0, 1'b1}},
		'{'{REQ_RD_CPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b1, '{CPSR_RESET, 1'b0, 1'b0}},
		'{'{REQ_UNUSED, 4'd15, 32'hFFFF_FFFF, COND_NV}, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{'{REQ_WR_REG, 4'd13, 32'hFFFF_FFFF, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_REG, 4'd8, 32'hA5A5_A5A5, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_SPSR, 4'd0, 32'hFFFF_FFFF, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_SPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_CPSR, 4'd0, 32'hF000_0011, COND_EQ}, 1'b0, '0},
		'{'{REQ_COND, 4'd0, 32'h0000_0000, COND_GT}, 1'b0, '0},
		'{'{REQ_RD_REG, 4'd8, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_REG, 4'd13, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_REG, 4'd8, 32'h0000_0001, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_CPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_SPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_SPSR, 4'd0, 32'hDEAD_BEEF, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_REG, 4'd8, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_CPSR, 4'd0, 32'h0000_001F, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_REG, 4'd13, 32'h0000_0000, COND_EQ}, 1'b0, '0},
		'{'{REQ_WR_CPSR, 4'd0, 32'h4000_0012, COND_EQ}, 1'b0, '0},
		'{'{REQ_RD_SPSR, 4'd0, 32'h0000_0000, COND_EQ}, 1'b0, '0}
	};

	banked_register_file_with_psr_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	function automatic bank_t bank_for(input logic [4:0] mode, output bit known);
		bank_t b;
		known = 1'b1;
		case (mode)
			MODE_USR, MODE_SYS: b = BANK_USR;
			MODE_FIQ: b = BANK_FIQ;
			MODE_IRQ: b = BANK_IRQ;
			MODE_SVC: b = BANK_SVC;
			MODE_ABT: b = BANK_ABT;
			MODE_UND: b = BANK_UND;
			default: begin
				b = BANK_USR;
				known = 1'b0;
			end
		endcase
		return b;
	endfunction

	function automatic out_word_t apply_request(input in_word_t w);
		out_word_t r;
		bank_t b;
		bit known;
		logic [31:0] psr;
		logic n, z, c, v;
		logic fiq_hi;
		r = '0;
		b = bank_for(cpsr[4:0], known);
		{n, z, c, v} = cpsr[31:28];
		fiq_hi = (b == BANK_FIQ) && (w.reg_index >= 4'd8) && (w.reg_index <= 4'd12);
		case (w.req_type)
			REQ_RD_REG: begin
				if (w.reg_index == 4'd13) r.read_data = sp_bank[b];
				else if (w.reg_index == 4'd14) r.read_data = lr_bank[b];
				else if (fiq_hi) r.read_data = gpr_fiq[w.reg_index];
				else r.read_data = gpr_common[w.reg_index];
			end
			REQ_WR_REG: begin
				if (w.reg_index == 4'd13) sp_bank[b] = w.write_data;
				else if (w.reg_index == 4'd14) lr_bank[b] = w.write_data;
				else if (fiq_hi) gpr_fiq[w.reg_index] = w.write_data;
				else gpr_common[w.reg_index] = w.write_data;
			end
			REQ_RD_CPSR: r.read_data = cpsr;
			REQ_WR_CPSR: begin
				psr = w.write_data | PSR_MODE_BIT4;
				void'(bank_for(psr[4:0], known));
				if (known) cpsr = psr;
				else r.status = 1'b1;
			end
			REQ_RD_SPSR: r.read_data = (b == BANK_USR) ? cpsr : saved_psr[b];
			REQ_WR_SPSR: begin
				if (b != BANK_USR) saved_psr[b] = w.write_data;
			end
			REQ_COND: begin
				case (cond_t'(w.cond_code))
					COND_EQ: r.cond_pass = z;
					COND_NE: r.cond_pass = !z;
					COND_CS: r.cond_pass = c;
					COND_CC: r.cond_pass = !c;
					COND_MI: r.cond_pass = n;
					COND_PL: r.cond_pass = !n;
					COND_VS: r.cond_pass = v;
					COND_VC: r.cond_pass = !v;
					COND_HI: r.cond_pass = c && !z;
					COND_LS: r.cond_pass = !c || z;
					COND_GE: r.cond_pass = n == v;
					COND_LT: r.cond_pass = n != v;
					COND_GT: r.cond_pass = !z && (n == v);
					COND_LE: r.cond_pass = z || (n != v);
					COND_AL: r.cond_pass = 1'b1;
					default: r.cond_pass = 1'b0;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want,
			input bit bursty);
		int gap;
		int roll;
		out_word_t predicted;
		gap = 0;
		roll = $urandom_range(0, 99);
		if (!bursty) begin
			if (roll >= 93) gap = $urandom_range(8, 30);
			else if (roll >= 60) gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = apply_request(w);
		pending_results.push_back(typed ? want : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		in_word_t w;
		int roll;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].want, 1'b0);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			roll = $urandom_range(0, 99);
			w.reg_index = 4'($urandom_range(0, 15));
			w.write_data = $urandom;
			w.cond_code = 4'($urandom_range(0, 15));
			if (roll < 20) begin
				w.req_type = REQ_RD_REG;
			end else if (roll < 40) begin
				w.req_type = REQ_WR_REG;
			end else if (roll < 47) begin
				w.req_type = REQ_RD_CPSR;
			end else if (roll < 60) begin
				w.req_type = REQ_WR_CPSR;
				if ($urandom_range(0, 9) != 0)
					w.write_data[4:0] = legal_modes[$urandom_range(0, 6)];
			end else if (roll < 67) begin
				w.req_type = REQ_RD_SPSR;
			end else if (roll < 74) begin
				w.req_type = REQ_WR_SPSR;
			end else if (roll < 98) begin
				w.req_type = REQ_COND;
			end else begin
				w.req_type = REQ_UNUSED;
			end
			send_word(w, 1'b0, '0, ((i / 128) % 4) == 1);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int stall_left;
		int roll;
		bit long_hold_done;
		out_word_t want;
		stall_left = 0;
		long_hold_done = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word", out_data.read_data, '0);
				end else begin
					want = pending_results.pop_front();
					if (out_data.read_data !== want.read_data)
						report_mismatch("read_data", out_data.read_data, want.read_data);
					if (out_data.cond_pass !== want.cond_pass)
						report_mismatch("cond_pass", 32'(out_data.cond_pass),
							32'(want.cond_pass));
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 300) begin
				// hold off long enough to back up the input side
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if ((results_seen / 200) % 3 == 2 || roll < 70) begin
					out_ready <= 1'b1;
				end else begin
					stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
					out_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule

[banked_register_file_with_psr_top.f]
hw/rtl/brf_pkg.sv
hw/rtl/brf_gpr.sv
hw/rtl/banked_register_file_with_psr_top.sv
bench/banked_register_file_with_psr_top_tb.sv
